### rtl/salcp_pkg.sv
package salcp_pkg;

  // Fixed field widths of the request and response words
  localparam int FW      = 10;
  localparam int SYM_W   = 8;
  localparam int STAT_W  = 2;

  // Default sizing
  localparam int MAX_LEN_DEF  = 1023;
  localparam int ALPHABET_DEF = 256;

  // Request modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Response status codes
  localparam logic [STAT_W-1:0] ST_BUILT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_READ_OK = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] ST_TRUNC   = 2'd3;

endpackage

### rtl/salcp_req_if.sv
interface salcp_req_if import salcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic [FW-1:0]    rank;

  modport source (output valid, mode, symbol, last, rank, input ready);
  modport sink   (input valid, mode, symbol, last, rank, output ready);
endinterface

### rtl/salcp_rsp_if.sv
interface salcp_rsp_if import salcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FW-1:0]     suffix_start;
  logic [FW-1:0]     common_prefix;
  logic [FW-1:0]     string_length;

  modport source (output valid, status, suffix_start, common_prefix, string_length,
                  input ready);
  modport sink   (input valid, status, suffix_start, common_prefix, string_length,
                  output ready);
endinterface

### rtl/salcp_ram.sv
module salcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/suffix_array_lcp_builder_core.sv
// Channel  Modport  Fields                                              Accept
// req      sink     mode, symbol, last, rank                            valid & ready
// rsp      source   status, suffix_start, common_prefix, string_length  valid & ready
//
// A load word with last starts the build. The build sorts in rounds (one per
// doubling step plus the first by symbol), then Kasai's pass fills the LCP array.
// Every array sits in a single-port-read RAM, one access per cycle, which sets the
// order of the steps. A read word addresses the order and LCP RAMs in S_IDLE, and
// its result is registered in S_RD. req.ready is low while the build runs and
// while an unclaimed result waits. Synchronous reset clears control only.
module suffix_array_lcp_builder_core import salcp_pkg::*; #(
  parameter int MAX_LEN       = MAX_LEN_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_DEF
) (
  input logic         clk,
  input logic         rst,
  salcp_req_if.sink   req,
  salcp_rsp_if.source rsp
);

  localparam int AW        = $clog2(MAX_LEN + 1);   // index of a cyclic shift
  localparam int CW        = $clog2(MAX_LEN + 2);   // bucket count
  localparam int TW        = $clog2(MAX_LEN);       // text / LCP address
  localparam int ALPHA     = ALPHABET_SIZE + 1;     // symbols plus sentinel
  localparam int BKT_DEPTH = (ALPHA > MAX_LEN + 1) ? ALPHA : MAX_LEN + 1;
  localparam int KW        = $clog2(BKT_DEPTH);     // class / key
  localparam int KCW       = $clog2(BKT_DEPTH + 1); // class count
  localparam int IW        = (CW > KCW) ? CW : KCW; // loop counter
  localparam int WW        = IW + 2;                // wrap sums
  localparam int XW        = (AW > FW) ? AW : FW;

  // Sequencer codes
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT_A = 5'd1;
  localparam logic [4:0] S_INIT_B = 5'd2;
  localparam logic [4:0] S_CLR    = 5'd3;
  localparam logic [4:0] S_CNT_A  = 5'd4;
  localparam logic [4:0] S_CNT_B  = 5'd5;
  localparam logic [4:0] S_CNT_C  = 5'd6;
  localparam logic [4:0] S_CNT_D  = 5'd7;
  localparam logic [4:0] S_PS_A   = 5'd8;
  localparam logic [4:0] S_PS_B   = 5'd9;
  localparam logic [4:0] S_PL_A   = 5'd10;
  localparam logic [4:0] S_PL_B   = 5'd11;
  localparam logic [4:0] S_PL_C   = 5'd12;
  localparam logic [4:0] S_PL_D   = 5'd13;
  localparam logic [4:0] S_CL_A   = 5'd14;
  localparam logic [4:0] S_CL_B   = 5'd15;
  localparam logic [4:0] S_CL_C   = 5'd16;
  localparam logic [4:0] S_CL_D   = 5'd17;
  localparam logic [4:0] S_CP_A   = 5'd18;
  localparam logic [4:0] S_CP_B   = 5'd19;
  localparam logic [4:0] S_SH_A   = 5'd20;
  localparam logic [4:0] S_SH_B   = 5'd21;
  localparam logic [4:0] S_RK_A   = 5'd22;
  localparam logic [4:0] S_RK_B   = 5'd23;
  localparam logic [4:0] S_KA     = 5'd24;
  localparam logic [4:0] S_KB     = 5'd25;
  localparam logic [4:0] S_KC     = 5'd26;
  localparam logic [4:0] S_KD     = 5'd27;
  localparam logic [4:0] S_KE     = 5'd28;
  localparam logic [4:0] S_KF     = 5'd29;
  localparam logic [4:0] S_RD     = 5'd30;

  // Control state
  logic [4:0]     state;
  logic [AW-1:0]  n;
  logic           built;
  logic           ovf;
  logic           ovalid;

  // Working registers
  logic [IW-1:0]  cnt;
  logic [CW:0]    step;
  logic [KCW-1:0] classes;
  logic [CW-1:0]  acc;
  logic [KW-1:0]  key;
  logic [AW-1:0]  val;
  logic [AW-1:0]  a_idx;
  logic [KW-1:0]  ca;
  logic [KW-1:0]  pca;
  logic [KW-1:0]  pcas;
  logic [KW-1:0]  cnum;
  logic [AW-1:0]  r;
  logic [AW-1:0]  j;
  logic [AW-1:0]  k;
  logic [SYM_W-1:0] ti;
  logic           rd_last;

  // Result register
  logic [STAT_W-1:0] o_status;
  logic [FW-1:0]     o_start;
  logic [FW-1:0]     o_lcp;
  logic [FW-1:0]     o_len;

  // RAM ports
  logic             txt_we;
  logic [TW-1:0]    txt_wa, txt_ra;
  logic [SYM_W-1:0] txt_wd, txt_rd;
  logic             ord_we;
  logic [AW-1:0]    ord_wa, ord_ra, ord_wd, ord_rd;
  logic             shf_we;
  logic [AW-1:0]    shf_wa, shf_ra, shf_wd, shf_rd;
  logic             cls_we;
  logic [AW-1:0]    cls_wa, cls_ra;
  logic [KW-1:0]    cls_wd, cls_rd;
  logic             ncl_we;
  logic [AW-1:0]    ncl_wa, ncl_ra;
  logic [KW-1:0]    ncl_wd, ncl_rd;
  logic             bkt_we;
  logic [KW-1:0]    bkt_wa, bkt_ra;
  logic [CW-1:0]    bkt_wd, bkt_rd;
  logic             rnk_we;
  logic [AW-1:0]    rnk_wa, rnk_ra, rnk_wd, rnk_rd;
  logic             lcp_we;
  logic [TW-1:0]    lcp_wa, lcp_ra;
  logic [AW-1:0]    lcp_wd, lcp_rd;

  // Derived values
  logic             acc_in;
  logic [AW-1:0]    n_eff;
  logic             room;
  logic [SYM_W-1:0] sym_sat;
  logic             rank_ok;
  logic [IW-1:0]    tot;
  logic [WW-1:0]    sum_cls;
  logic [AW-1:0]    wrap_cls;
  logic [WW-1:0]    sum_shf;
  logic [AW-1:0]    wrap_shf;
  logic             diff;
  logic [KW-1:0]    cnum_new;
  logic [CW:0]      nstep;
  logic             k_bound;
  logic             k_last;

  assign acc_in  = req.valid && req.ready;
  assign n_eff   = built ? '0 : n;
  assign room    = IW'(n_eff) < IW'(MAX_LEN);
  assign sym_sat = ((SYM_W + 1)'(req.symbol) >= (SYM_W + 1)'(ALPHABET_SIZE)) ?
                   SYM_W'(ALPHABET_SIZE - 1) : req.symbol;
  assign rank_ok = built && (XW'(req.rank) < XW'(n));
  assign tot     = IW'(n) + IW'(1);

  // Partner shift for the class compare: (a + step) mod total
  assign sum_cls  = WW'(a_idx) + WW'(step);
  assign wrap_cls = (sum_cls >= WW'(tot)) ? AW'(sum_cls - WW'(tot)) : AW'(sum_cls);
  // Shifted start: (order + total - step) mod total
  assign sum_shf  = WW'(ord_rd) + WW'(tot) - WW'(step);
  assign wrap_shf = (sum_shf >= WW'(tot)) ? AW'(sum_shf - WW'(tot)) : AW'(sum_shf);

  assign diff     = (cnt != '0) && ((ca != pca) || (cls_rd != pcas));
  assign cnum_new = (cnt == '0) ? '0 : cnum + KW'(diff);
  assign nstep    = (step == '0) ? (CW + 1)'(1) : (step << 1);

  assign k_bound  = ((IW'(cnt) + IW'(k)) < IW'(n)) && ((IW'(j) + IW'(k)) < IW'(n));
  assign k_last   = (cnt == IW'(n) - IW'(1));

  assign req.ready         = (state == S_IDLE) && (!ovalid || rsp.ready);
  assign rsp.valid         = ovalid;
  assign rsp.status        = o_status;
  assign rsp.suffix_start  = o_start;
  assign rsp.common_prefix = o_lcp;
  assign rsp.string_length = o_len;

  // RAM address and write steering
  always_comb begin
    txt_we = 1'b0; txt_wa = '0; txt_wd = '0; txt_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    shf_we = 1'b0; shf_wa = '0; shf_wd = '0; shf_ra = '0;
    cls_we = 1'b0; cls_wa = '0; cls_wd = '0; cls_ra = '0;
    ncl_we = 1'b0; ncl_wa = '0; ncl_wd = '0; ncl_ra = '0;
    bkt_we = 1'b0; bkt_wa = '0; bkt_wd = '0; bkt_ra = '0;
    rnk_we = 1'b0; rnk_wa = '0; rnk_wd = '0; rnk_ra = '0;
    lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0; lcp_ra = '0;
    case (state)
      S_IDLE: begin
        txt_we = acc_in && (req.mode == MODE_LOAD) && room;
        txt_wa = TW'(n_eff);
        txt_wd = sym_sat;
        ord_ra = AW'(XW'(req.rank) + XW'(1));
        lcp_ra = TW'(req.rank);
      end
      S_INIT_A: txt_ra = TW'(cnt);
      S_INIT_B: begin
        shf_we = 1'b1;
        shf_wa = AW'(cnt);
        shf_wd = AW'(cnt);
        cls_we = 1'b1;
        cls_wa = AW'(cnt);
        cls_wd = (cnt < IW'(n)) ? KW'(txt_rd) + KW'(1) : '0;
      end
      S_CLR: begin
        bkt_we = 1'b1;
        bkt_wa = KW'(cnt);
      end
      S_CNT_A: shf_ra = AW'(cnt);
      S_CNT_B: cls_ra = shf_rd;
      S_CNT_C: bkt_ra = cls_rd;
      S_CNT_D: begin
        bkt_we = 1'b1;
        bkt_wa = key;
        bkt_wd = bkt_rd + CW'(1);
      end
      S_PS_A: bkt_ra = KW'(cnt);
      S_PS_B: begin
        bkt_we = 1'b1;
        bkt_wa = KW'(cnt);
        bkt_wd = acc + bkt_rd;
      end
      S_PL_A: shf_ra = AW'(cnt);
      S_PL_B: cls_ra = shf_rd;
      S_PL_C: bkt_ra = cls_rd;
      S_PL_D: begin
        bkt_we = 1'b1;
        bkt_wa = key;
        bkt_wd = bkt_rd - CW'(1);
        ord_we = 1'b1;
        ord_wa = AW'(bkt_rd - CW'(1));
        ord_wd = val;
      end
      S_CL_A: ord_ra = AW'(cnt);
      S_CL_B: cls_ra = ord_rd;
      S_CL_C: cls_ra = wrap_cls;
      S_CL_D: begin
        ncl_we = 1'b1;
        ncl_wa = a_idx;
        ncl_wd = cnum_new;
      end
      S_CP_A: ncl_ra = AW'(cnt);
      S_CP_B: begin
        cls_we = 1'b1;
        cls_wa = AW'(cnt);
        cls_wd = ncl_rd;
      end
      S_SH_A: ord_ra = AW'(cnt);
      S_SH_B: begin
        shf_we = 1'b1;
        shf_wa = AW'(cnt);
        shf_wd = wrap_shf;
      end
      S_RK_A: ord_ra = AW'(cnt + IW'(1));
      S_RK_B: begin
        rnk_we = 1'b1;
        rnk_wa = ord_rd;
        rnk_wd = AW'(cnt);
      end
      S_KA: rnk_ra = AW'(cnt);
      S_KB: ord_ra = AW'(IW'(rnk_rd) + IW'(2));
      S_KD: txt_ra = TW'(IW'(cnt) + IW'(k));
      S_KE: txt_ra = TW'(IW'(j) + IW'(k));
      default: ;
    endcase
    // Close the LCP of this suffix when the match stops
    if ((state == S_KD && !k_bound) || (state == S_KF && ti != txt_rd)) begin
      lcp_we = 1'b1;
      lcp_wa = TW'(r);
      lcp_wd = k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      n      <= '0;
      built  <= 1'b0;
      ovf    <= 1'b0;
      ovalid <= 1'b0;
      step   <= '0;
    end else begin
      if (ovalid && rsp.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in && req.mode == MODE_LOAD) begin
            // Drop the old string on the first load after a build
            built <= 1'b0;
            n     <= room ? n_eff + AW'(1) : n_eff;
            ovf   <= (built ? 1'b0 : ovf) | !room;
            if (req.last) begin
              cnt     <= '0;
              step    <= '0;
              classes <= KCW'(ALPHA);
              state   <= S_INIT_A;
            end
          end else if (acc_in) begin
            if (rank_ok) begin
              rd_last <= (XW'(req.rank) + XW'(1)) >= XW'(n);
              state   <= S_RD;
            end else begin
              ovalid   <= 1'b1;
              o_status <= ST_INVALID;
              o_start  <= '0;
              o_lcp    <= '0;
              o_len    <= built ? FW'(n) : '0;
            end
          end
        end
        S_INIT_A: state <= S_INIT_B;
        S_INIT_B: begin
          if (cnt == tot - IW'(1)) begin
            cnt   <= '0;
            state <= S_CLR;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_INIT_A;
          end
        end
        S_CLR: begin
          if (cnt == IW'(classes) - IW'(1)) begin
            cnt   <= '0;
            state <= S_CNT_A;
          end else begin
            cnt <= cnt + IW'(1);
          end
        end
        S_CNT_A: state <= S_CNT_B;
        S_CNT_B: state <= S_CNT_C;
        S_CNT_C: begin
          key   <= cls_rd;
          state <= S_CNT_D;
        end
        S_CNT_D: begin
          if (cnt == tot - IW'(1)) begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_PS_A;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_CNT_A;
          end
        end
        S_PS_A: state <= S_PS_B;
        S_PS_B: begin
          acc <= acc + bkt_rd;
          if (cnt == IW'(classes) - IW'(1)) begin
            cnt   <= tot - IW'(1);
            state <= S_PL_A;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_PS_A;
          end
        end
        S_PL_A: state <= S_PL_B;
        S_PL_B: begin
          val   <= shf_rd;
          state <= S_PL_C;
        end
        S_PL_C: begin
          key   <= cls_rd;
          state <= S_PL_D;
        end
        S_PL_D: begin
          if (cnt == '0) begin
            state <= S_CL_A;
          end else begin
            cnt   <= cnt - IW'(1);
            state <= S_PL_A;
          end
        end
        S_CL_A: state <= S_CL_B;
        S_CL_B: begin
          a_idx <= ord_rd;
          state <= S_CL_C;
        end
        S_CL_C: begin
          ca    <= cls_rd;
          state <= S_CL_D;
        end
        S_CL_D: begin
          cnum <= cnum_new;
          pca  <= ca;
          pcas <= cls_rd;
          if (cnt == tot - IW'(1)) begin
            classes <= KCW'(cnum_new) + KCW'(1);
            cnt     <= '0;
            state   <= S_CP_A;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_CL_A;
          end
        end
        S_CP_A: state <= S_CP_B;
        S_CP_B: begin
          if (cnt == tot - IW'(1)) begin
            cnt  <= '0;
            step <= nstep;
            // Next doubling round, or on to the LCP pass
            state <= ((CW + 1)'(tot) > nstep) ? S_SH_A : S_RK_A;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_CP_A;
          end
        end
        S_SH_A: state <= S_SH_B;
        S_SH_B: begin
          if (cnt == tot - IW'(1)) begin
            cnt   <= '0;
            state <= S_CLR;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_SH_A;
          end
        end
        S_RK_A: state <= S_RK_B;
        S_RK_B: begin
          if (k_last) begin
            cnt   <= '0;
            k     <= '0;
            state <= S_KA;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_RK_A;
          end
        end
        S_KA: state <= S_KB;
        S_KB: begin
          r <= rnk_rd;
          if ((IW'(rnk_rd) + IW'(1)) >= IW'(n)) begin
            // Last rank: no successor, restart the match length
            k <= '0;
            if (k_last) begin
              built    <= 1'b1;
              ovalid   <= 1'b1;
              o_status <= ovf ? ST_TRUNC : ST_BUILT;
              o_start  <= '0;
              o_lcp    <= '0;
              o_len    <= FW'(n);
              state    <= S_IDLE;
            end else begin
              cnt   <= cnt + IW'(1);
              state <= S_KA;
            end
          end else begin
            state <= S_KC;
          end
        end
        S_KC: begin
          j     <= ord_rd;
          state <= S_KD;
        end
        S_KD, S_KF: begin
          if (state == S_KD && k_bound) begin
            state <= S_KE;
          end else if (state == S_KF && ti == txt_rd) begin
            k     <= k + AW'(1);
            state <= S_KD;
          end else begin
            k <= (k != '0) ? k - AW'(1) : '0;
            if (k_last) begin
              built    <= 1'b1;
              ovalid   <= 1'b1;
              o_status <= ovf ? ST_TRUNC : ST_BUILT;
              o_start  <= '0;
              o_lcp    <= '0;
              o_len    <= FW'(n);
              state    <= S_IDLE;
            end else begin
              cnt   <= cnt + IW'(1);
              state <= S_KA;
            end
          end
        end
        S_KE: begin
          ti    <= txt_rd;
          state <= S_KF;
        end
        S_RD: begin
          ovalid   <= 1'b1;
          o_status <= ST_READ_OK;
          o_start  <= FW'(ord_rd);
          o_lcp    <= rd_last ? '0 : FW'(lcp_rd);
          o_len    <= FW'(n);
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  salcp_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_txt (
    .clk, .we(txt_we), .waddr(txt_wa), .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd));
  salcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN + 1)) u_ord (
    .clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
  salcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN + 1)) u_shf (
    .clk, .we(shf_we), .waddr(shf_wa), .wdata(shf_wd), .raddr(shf_ra), .rdata(shf_rd));
  salcp_ram #(.WIDTH(KW), .DEPTH(MAX_LEN + 1)) u_cls (
    .clk, .we(cls_we), .waddr(cls_wa), .wdata(cls_wd), .raddr(cls_ra), .rdata(cls_rd));
  salcp_ram #(.WIDTH(KW), .DEPTH(MAX_LEN + 1)) u_ncl (
    .clk, .we(ncl_we), .waddr(ncl_wa), .wdata(ncl_wd), .raddr(ncl_ra), .rdata(ncl_rd));
  salcp_ram #(.WIDTH(CW), .DEPTH(BKT_DEPTH)) u_bkt (
    .clk, .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_rd));
  salcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN + 1)) u_rnk (
    .clk, .we(rnk_we), .waddr(rnk_wa), .wdata(rnk_wd), .raddr(rnk_ra), .rdata(rnk_rd));
  salcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_lcp (
    .clk, .we(lcp_we), .waddr(lcp_wa), .wdata(lcp_wd), .raddr(lcp_ra), .rdata(lcp_rd));

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    IW'(n) <= IW'(MAX_LEN))
    else $error("loaded length beyond capacity");

  a_step_pow2: assert property (@(posedge clk) disable iff (rst)
    $onehot0(step))
    else $error("doubling step is not a power of two");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CL_D) |-> (IW'(cnum_new) < tot))
    else $error("class number reaches the shift count");

  a_read_unbuilt: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.mode == MODE_READ && !built)
    |=> (rsp.valid && rsp.status == ST_INVALID))
    else $error("read before build not rejected");

  a_build_word: assert property (@(posedge clk) disable iff (rst)
    $rose(built) |-> (rsp.valid && (rsp.status == ST_BUILT || rsp.status == ST_TRUNC)))
    else $error("build finished without its result word");

endmodule
